@@ rtl/core/slt_pkg.sv @@
// slt_pkg: operation and status codes of the sorted list table.
// No dependencies; imported by slt_seq and sorted_list_table.
`timescale 1ns / 1ps
`default_nettype none

package slt_pkg;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_SEARCH = 2'd1,
    OP_DELETE = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_DONE   = 2'd0,
    ST_ABSENT = 2'd1,
    ST_FULL   = 2'd2
  } status_e;

endpackage

`default_nettype wire

@@ rtl/core/slt_ram.sv @@
// slt_ram: entry store, one write port and one read port with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module slt_ram #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [31:0]   wdata_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [31:0]   rdata_o
);

  logic [31:0] mem_q [DEPTH];
  logic [31:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ rtl/core/slt_seq.sv @@
// slt_seq: sequencer that walks the entry store one word per cycle through a
// single signed compare unit; holds the entry count. Depends on slt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module slt_seq
  import slt_pkg::*;
#(
  parameter int unsigned CAPACITY = 16,
  parameter int unsigned AW       = 4,
  parameter int unsigned CW       = 5
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 req_valid_i,
  output logic                      req_ready_o,
  input  wire logic [1:0]           op_i,
  input  wire logic signed [31:0]   value_i,
  output logic                      res_valid_o,
  input  wire logic                 res_ready_i,
  output status_e                   res_status_o,
  output logic      [CW-1:0]        count_o,
  output logic                      mem_we_o,
  output logic      [AW-1:0]        mem_waddr_o,
  output logic      [31:0]          mem_wdata_o,
  output logic      [AW-1:0]        mem_raddr_o,
  input  wire logic [31:0]          mem_rdata_i
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_INS   = 5'b00010,
    S_SCAN  = 5'b00100,
    S_SHIFT = 5'b01000,
    S_FIN   = 5'b10000
  } state_e;

  localparam logic [CW-1:0] CapC = CW'(CAPACITY);
  localparam logic [CW-1:0] OneC = CW'(1);
  localparam logic [CW-1:0] TwoC = CW'(2);

  state_e               state_q, state_d;
  logic    [CW-1:0]     idx_q, idx_d;
  logic    [CW-1:0]     count_q, count_d;
  logic signed [31:0]   val_q, val_d;
  logic                 del_q, del_d;
  status_e              status_q, status_d;
  logic    [CW-1:0]     ridx;
  logic                 lt, eq;

  // shared compare unit
  assign lt = $signed(mem_rdata_i) < val_q;
  assign eq = mem_rdata_i == val_q;

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    count_d     = count_q;
    val_d       = val_q;
    del_d       = del_q;
    status_d    = status_q;
    ridx        = '0;
    mem_we_o    = 1'b0;
    mem_wdata_o = val_q;
    req_ready_o = 1'b0;
    res_valid_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          val_d = value_i;
          del_d = (op_i == OP_DELETE);
          case (op_e'(op_i))
            OP_INSERT: begin
              if (count_q == CapC) begin
                status_d = ST_FULL;
                state_d  = S_FIN;
              end else begin
                idx_d   = count_q;
                ridx    = count_q - OneC;
                state_d = S_INS;
              end
            end
            OP_SEARCH, OP_DELETE: begin
              idx_d   = '0;
              state_d = S_SCAN;
            end
            default: begin
              status_d = ST_DONE;
              state_d  = S_FIN;
            end
          endcase
        end
      end
      S_INS: begin
        mem_we_o = 1'b1;
        if (idx_q == '0 || lt) begin
          count_d  = count_q + OneC;
          status_d = ST_DONE;
          state_d  = S_FIN;
        end else begin
          mem_wdata_o = mem_rdata_i;
          idx_d       = idx_q - OneC;
          ridx        = idx_q - TwoC;
        end
      end
      S_SCAN: begin
        if (idx_q == count_q) begin
          status_d = ST_ABSENT;
          state_d  = S_FIN;
        end else if (lt) begin
          idx_d = idx_q + OneC;
          ridx  = idx_q + OneC;
        end else if (!eq) begin
          status_d = ST_ABSENT;
          state_d  = S_FIN;
        end else if (!del_q) begin
          status_d = ST_DONE;
          state_d  = S_FIN;
        end else begin
          ridx    = idx_q + OneC;
          state_d = S_SHIFT;
        end
      end
      S_SHIFT: begin
        if (idx_q + OneC == count_q) begin
          count_d  = count_q - OneC;
          status_d = ST_DONE;
          state_d  = S_FIN;
        end else begin
          mem_we_o    = 1'b1;
          mem_wdata_o = mem_rdata_i;
          idx_d       = idx_q + OneC;
          ridx        = idx_q + TwoC;
        end
      end
      S_FIN: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign mem_waddr_o  = idx_q[AW-1:0];
  assign mem_raddr_o  = ridx[AW-1:0];
  assign res_status_o = status_q;
  assign count_o      = count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    val_q    <= val_d;
    del_q    <= del_d;
    status_q <= status_d;
  end

endmodule

`default_nettype wire

@@ rtl/core/sorted_list_table.sv @@
// sorted_list_table: ascending table of signed 32-bit words with insert, search, delete.
// One word in flight; one entry read per cycle while the table is walked. A full insert or an
// unused op finishes without a walk. The next word is taken only after the result has passed
// into the output register.
// Reset clears the count and control; entry contents stay undefined, no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module sorted_list_table
  import slt_pkg::*;
#(
  parameter int unsigned CAPACITY = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [1:0]         op_i,
  input  wire logic signed [31:0] value_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic      [1:0]         status_o,
  output logic      [4:0]         entry_count_o
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  logic          res_valid, res_ready;
  status_e       res_status;
  logic [CW-1:0] res_count;
  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [31:0]   mem_wdata, mem_rdata;

  logic          out_valid_q;
  status_e       out_status_q;
  logic [CW-1:0] out_count_q;
  logic [CW+4:0] count_ext;

  slt_seq #(
    .CAPACITY(CAPACITY),
    .AW      (AW),
    .CW      (CW)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (in_valid_i),
    .req_ready_o (in_ready_o),
    .op_i        (op_i),
    .value_i     (value_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_status_o(res_status),
    .count_o     (res_count),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  slt_ram #(
    .DEPTH(CAPACITY),
    .AW   (AW)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_status_q <= res_status;
      out_count_q  <= res_count;
    end
  end

  assign count_ext     = (CW + 5)'(out_count_q);
  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign entry_count_o = count_ext[4:0];

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_count <= CW'(CAPACITY))
    else $error("entry count beyond capacity");

  a_idle_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !res_valid)
    else $error("result pending while sequencer idle");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("word accepted while previous one in flight");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_status_q == ST_FULL) |-> out_count_q == CW'(CAPACITY))
    else $error("full status without full table");

endmodule

`default_nettype wire
